>>> rtl/core/fraction_arithmetic_reduce_unit_defines.svh
// Assertion macros shared by the fraction reduce unit RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef FRACTION_ARITHMETIC_REDUCE_UNIT_DEFINES_SVH
`define FRACTION_ARITHMETIC_REDUCE_UNIT_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent
`define FAR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent
`define FAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/far_pkg.sv
// Package for the fraction reduce unit: field widths, command codes,
// sequencer states and the divider status bundle. No dependencies.
package far_pkg;

    localparam int CMD_BITS         = 2;
    localparam int NUM_BITS         = 33;
    localparam int DEN_BITS         = 32;
    localparam int OPERAND_BITS_DEF = 16;

    localparam logic [CMD_BITS-1:0] CMD_ADD = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_SUB = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_MUL = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_DIV = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_CHECK,
        ST_GCD_ISSUE,
        ST_GCD_WAIT,
        ST_QNUM_ISSUE,
        ST_QNUM_WAIT,
        ST_QDEN_ISSUE,
        ST_QDEN_WAIT,
        ST_FINISH
    } far_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

>>> rtl/core/fraction_arithmetic_reduce_unit.sv
// Fraction arithmetic with GCD reduction, DW = 2*OPERAND_BITS+1 (33 at the default width).
// A new word is accepted only in idle, so one word is in flight at a time; the bit-serial
// divider is shared by Euclid and both final divisions. A zero denominator skips the divider
// and returns an undefined result.
// Reset (rst_n, async low) returns the sequencer to idle and drops out_valid.
// Depends on far_pkg, far_div and fraction_arithmetic_reduce_unit_defines.svh.
`include "fraction_arithmetic_reduce_unit_defines.svh"

module fraction_arithmetic_reduce_unit #(
    parameter int OPERAND_BITS = far_pkg::OPERAND_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [far_pkg::CMD_BITS-1:0]        command,
    input  logic signed [OPERAND_BITS-1:0]      a_num,
    input  logic signed [OPERAND_BITS-1:0]      a_den,
    input  logic signed [OPERAND_BITS-1:0]      b_num,
    input  logic signed [OPERAND_BITS-1:0]      b_den,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [far_pkg::NUM_BITS-1:0] res_num,
    output logic signed [far_pkg::DEN_BITS-1:0] res_den,
    output logic                                undefined
);
    import far_pkg::*;

    localparam int PW = 2 * OPERAND_BITS;
    localparam int DW = 2 * OPERAND_BITS + 1;

    far_state_t state_reg, state_next;

    logic [CMD_BITS-1:0]           cmd_reg, cmd_next;
    logic signed [OPERAND_BITS-1:0] an_reg, an_next;
    logic signed [OPERAND_BITS-1:0] ad_reg, ad_next;
    logic signed [OPERAND_BITS-1:0] bn_reg, bn_next;
    logic signed [OPERAND_BITS-1:0] bd_reg, bd_next;
    logic signed [PW-1:0]          prod_reg, prod_next;
    logic signed [DW-1:0]          n_reg, n_next;
    logic signed [DW-1:0]          d_reg, d_next;
    logic signed [DW-1:0]          x_reg, x_next;
    logic signed [DW-1:0]          y_reg, y_next;
    logic                          undef_reg, undef_next;

    logic                          out_valid_reg, out_valid_next;
    logic signed [NUM_BITS-1:0]    res_num_reg, res_num_next;
    logic signed [DEN_BITS-1:0]    res_den_reg, res_den_next;
    logic                          res_undef_reg, res_undef_next;

    logic signed [OPERAND_BITS-1:0] mul_a, mul_b;
    logic signed [PW-1:0]          product;
    logic signed [DW-1:0]          prod_ext;

    logic                          div_start;
    logic [DW-1:0]                 div_dividend, div_divisor;
    logic [DW-1:0]                 div_quo, div_rem;
    div_status_t                   div_stat;

    logic signed [DW-1:0]          gcd_rem;
    logic signed [DW-1:0]          quo_signed;
    logic                          quo_neg;
    logic                          accept;
    logic                          load_out;
    logic                          div_wait;

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] neg;
        neg = -v;
        mag = v[DW-1] ? neg : v;
    endfunction

    assign accept   = in_valid && !in_stall;
    assign load_out = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);
    assign div_wait = (state_reg == ST_GCD_WAIT) || (state_reg == ST_QNUM_WAIT)
                      || (state_reg == ST_QDEN_WAIT);

    // Shared multiplier
    assign product  = mul_a * mul_b;
    assign prod_ext = DW'(prod_reg);

    // Signed remainder follows the sign of the dividend
    assign gcd_rem = x_reg[DW-1] ? -$signed(div_rem) : $signed(div_rem);

    // Signed quotient: negate when the operand signs differ
    assign quo_signed = quo_neg ? -$signed(div_quo) : $signed(div_quo);

    far_div #(
        .WIDTH (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .status    (div_stat)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (in_valid) state_next = ST_MUL0;
            ST_MUL0:       state_next = ST_MUL1;
            ST_MUL1:       state_next = ST_MUL2;
            ST_MUL2:       state_next = ST_CHECK;
            ST_CHECK:      state_next = (prod_reg == '0) ? ST_FINISH : ST_GCD_ISSUE;
            ST_GCD_ISSUE:  state_next = ST_GCD_WAIT;
            ST_GCD_WAIT:
            begin
                if (div_stat.done)
                    state_next = (gcd_rem == '0) ? ST_QNUM_ISSUE : ST_GCD_ISSUE;
            end
            ST_QNUM_ISSUE: state_next = ST_QNUM_WAIT;
            ST_QNUM_WAIT:  if (div_stat.done) state_next = ST_QDEN_ISSUE;
            ST_QDEN_ISSUE: state_next = ST_QDEN_WAIT;
            ST_QDEN_WAIT:  if (div_stat.done) state_next = ST_FINISH;
            ST_FINISH:     if (load_out) state_next = ST_IDLE;
        endcase
    end

    // Control outputs: handshake, multiplier and divider operand select
    always_comb
    begin
        in_stall     = (state_reg != ST_IDLE);
        mul_a        = an_reg;
        mul_b        = (cmd_reg == CMD_MUL) ? bn_reg : bd_reg;
        div_start    = 1'b0;
        div_dividend = mag(x_reg);
        div_divisor  = mag(y_reg);
        quo_neg      = n_reg[DW-1] ^ x_reg[DW-1];
        unique case (state_reg)
            ST_MUL1:
            begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            ST_MUL2:
            begin
                mul_a = ad_reg;
                mul_b = (cmd_reg == CMD_DIV) ? bn_reg : bd_reg;
            end
            ST_GCD_ISSUE:
            begin
                div_start = 1'b1;
            end
            ST_QNUM_ISSUE:
            begin
                div_start    = 1'b1;
                div_dividend = mag(n_reg);
                div_divisor  = mag(x_reg);
            end
            ST_QDEN_ISSUE:
            begin
                div_start    = 1'b1;
                div_dividend = mag(d_reg);
                div_divisor  = mag(x_reg);
            end
            ST_QDEN_WAIT:
            begin
                quo_neg = d_reg[DW-1] ^ x_reg[DW-1];
            end
            default:
            begin
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        cmd_next        = cmd_reg;
        an_next         = an_reg;
        ad_next         = ad_reg;
        bn_next         = bn_reg;
        bd_next         = bd_reg;
        prod_next       = prod_reg;
        n_next          = n_reg;
        d_next          = d_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        undef_next      = undef_reg;
        res_num_next    = res_num_reg;
        res_den_next    = res_den_reg;
        res_undef_next  = res_undef_reg;
        out_valid_next  = out_valid_reg && out_stall;

        // Capture the input word
        if (accept)
        begin
            cmd_next = command;
            an_next  = a_num;
            ad_next  = a_den;
            bn_next  = b_num;
            bd_next  = b_den;
        end

        unique case (state_reg)
            ST_MUL0:
            begin
                prod_next = product;
            end
            ST_MUL1:
            begin
                prod_next = product;
                n_next    = prod_ext;
            end
            ST_MUL2:
            begin
                prod_next = product;
                unique case (cmd_reg)
                    CMD_ADD: n_next = n_reg + prod_ext;
                    CMD_SUB: n_next = n_reg - prod_ext;
                    CMD_MUL: n_next = n_reg;
                    CMD_DIV: n_next = n_reg;
                endcase
            end
            ST_CHECK:
            begin
                // Zero denominator: flag and drop both terms
                if (prod_reg == '0)
                begin
                    undef_next = 1'b1;
                    n_next     = '0;
                    d_next     = '0;
                end
                else
                begin
                    undef_next = 1'b0;
                    d_next     = prod_ext;
                    x_next     = n_reg;
                    y_next     = prod_ext;
                end
            end
            ST_GCD_WAIT:
            begin
                // Euclid step: x takes y, y takes the remainder
                if (div_stat.done)
                begin
                    x_next = y_reg;
                    y_next = gcd_rem;
                end
            end
            ST_QNUM_WAIT:
            begin
                if (div_stat.done)
                    n_next = quo_signed;
            end
            ST_QDEN_WAIT:
            begin
                if (div_stat.done)
                    d_next = quo_signed;
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    res_num_next   = NUM_BITS'(n_reg);
                    res_den_next   = DEN_BITS'(d_reg);
                    res_undef_next = undef_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        an_reg        <= an_next;
        ad_reg        <= ad_next;
        bn_reg        <= bn_next;
        bd_reg        <= bd_next;
        prod_reg      <= prod_next;
        n_reg         <= n_next;
        d_reg         <= d_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        undef_reg     <= undef_next;
        res_num_reg   <= res_num_next;
        res_den_reg   <= res_den_next;
        res_undef_reg <= res_undef_next;
    end

    assign out_valid = out_valid_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign undefined = res_undef_reg;

    `FAR_ASSERT_NEXT(a_accept_starts_mul, accept, state_reg == ST_MUL0, "word not started")
    `FAR_ASSERT_SAME(a_div_done_in_wait, div_stat.done, div_wait, "stray divider done")
    `FAR_ASSERT_SAME(a_div_start_idle, div_start, !div_stat.busy, "divider restarted")
    `FAR_ASSERT_SAME(a_gcd_nonzero, state_reg == ST_QNUM_ISSUE, x_reg != '0, "zero divisor")
    `FAR_ASSERT_SAME(a_undef_zero, out_valid && undefined, {res_num, res_den} == '0, "bad undef")

endmodule

>>> rtl/core/far_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on far_pkg for the status bundle.
module far_div #(
    parameter int WIDTH = 2 * far_pkg::OPERAND_BITS_DEF + 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [WIDTH-1:0]          dividend,
    input  logic [WIDTH-1:0]          divisor,
    output logic [WIDTH-1:0]          quotient,
    output logic [WIDTH-1:0]          remainder,
    output far_pkg::div_status_t      status
);
    import far_pkg::*;

    localparam int CNT_BITS = $clog2(WIDTH + 1);

    logic [WIDTH-1:0]    rem_reg, rem_next;
    logic [WIDTH-1:0]    quo_reg, quo_next;
    logic [WIDTH-1:0]    dvs_reg, dvs_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [WIDTH-1:0]    trial;
    logic [WIDTH-1:0]    diff;
    logic                fits;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {rem_reg[WIDTH-2:0], quo_reg[WIDTH-1]};
    assign fits  = (trial >= dvs_reg);
    assign diff  = trial - dvs_reg;

    // Load on start, else advance one bit while busy
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_BITS'(WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff : trial;
            quo_next = {quo_reg[WIDTH-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
